[hw/rtl/foc_pwm_pkg.sv]
// Shared types, widths and the quarter-wave sine table for the FOC PWM block.
// No dependencies.
`default_nettype none
package foc_pwm_pkg;

   localparam int SEG_BITS = 5;
   localparam int SEGS     = 32;
   localparam int VOLT_W   = 16;   // Q8.8 voltage commands
   localparam int SUPPLY_W = 15;   // supply register
   localparam int SINE_W   = 17;   // signed sine/cosine, Q1.15 plus sign
   localparam int DIFF_W   = 11;   // largest table step is 1608
   localparam int MAG_W    = SUPPLY_W + 30;   // clamped phase voltage, 2^-38 V
   localparam logic [SUPPLY_W-1:0] SUPPLY_RESET = 15'd6144;
   localparam logic signed [15:0]  HALF_SQRT3_Q15 = 16'sd28378;

   typedef logic [SEG_BITS:0] seg_idx_type;
   typedef logic [14:0]       sine_mag_type;

   // sin(k*pi/64)*32767 for k = 0..32
   function automatic sine_mag_type quarter_sine(input seg_idx_type idx);
      sine_mag_type r;
      case (idx)
         6'd0:  r = 15'd0;     6'd1:  r = 15'd1608;  6'd2:  r = 15'd3212;
         6'd3:  r = 15'd4808;  6'd4:  r = 15'd6393;  6'd5:  r = 15'd7962;
         6'd6:  r = 15'd9512;  6'd7:  r = 15'd11039; 6'd8:  r = 15'd12539;
         6'd9:  r = 15'd14010; 6'd10: r = 15'd15446; 6'd11: r = 15'd16846;
         6'd12: r = 15'd18204; 6'd13: r = 15'd19519; 6'd14: r = 15'd20787;
         6'd15: r = 15'd22005; 6'd16: r = 15'd23170; 6'd17: r = 15'd24279;
         6'd18: r = 15'd25329; 6'd19: r = 15'd26319; 6'd20: r = 15'd27245;
         6'd21: r = 15'd28105; 6'd22: r = 15'd28898; 6'd23: r = 15'd29621;
         6'd24: r = 15'd30273; 6'd25: r = 15'd30852; 6'd26: r = 15'd31356;
         6'd27: r = 15'd31785; 6'd28: r = 15'd32137; 6'd29: r = 15'd32412;
         6'd30: r = 15'd32609; 6'd31: r = 15'd32728;
         default: r = 15'd32767;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/foc_phase_voltage_to_pwm.sv]
// Pipeline: two sine/cosine stages, four transform stages, one scale stage and one
// divider stage per duty bit. Throughput: one word per cycle unless rsp_ready stalls;
// every stage holds its own valid bit and fills bubbles.
// Reset (synchronous): pipeline emptied, supply register back to 6144 (24 V).
// Top level; uses foc_pwm_pkg, foc_pwm_sincos, foc_pwm_xform, foc_pwm_duty.
`default_nettype none
module foc_phase_voltage_to_pwm
   import foc_pwm_pkg::*;
#(
   parameter int ANGLE_BITS = 16,
   parameter int DUTY_MAX   = 255
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wr_en,
   input  wire logic [SUPPLY_W-1:0]      csr_wr_data,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [VOLT_W-1:0] req_volt_q,
   input  wire logic signed [VOLT_W-1:0] req_volt_d,
   input  wire logic [15:0]              req_elec_angle,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [7:0]                    rsp_duty_a,
   output logic [7:0]                    rsp_duty_b,
   output logic [7:0]                    rsp_duty_c
);

   logic [SUPPLY_W-1:0]      supply_ff;
   logic                     sc_valid, sc_ready;
   logic signed [VOLT_W-1:0] sc_vq, sc_vd;
   logic signed [SINE_W-1:0] sc_sin, sc_cos;
   logic                     xf_valid, xf_ready;
   logic [MAG_W-1:0]         xf_mag [3];
   logic [7:0]               duty [3];

   // supply register
   always_ff @(posedge clock) begin
      if (reset) supply_ff <= SUPPLY_RESET;
      else if (csr_wr_en) supply_ff <= csr_wr_data;
   end

   foc_pwm_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_volt_q  (req_volt_q),
      .in_volt_d  (req_volt_d),
      .in_angle   (req_elec_angle),
      .out_valid  (sc_valid),
      .out_ready  (sc_ready),
      .out_volt_q (sc_vq),
      .out_volt_d (sc_vd),
      .out_sin    (sc_sin),
      .out_cos    (sc_cos)
   );

   foc_pwm_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .supply    (supply_ff),
      .in_valid  (sc_valid),
      .in_ready  (sc_ready),
      .in_volt_q (sc_vq),
      .in_volt_d (sc_vd),
      .in_sin    (sc_sin),
      .in_cos    (sc_cos),
      .out_valid (xf_valid),
      .out_ready (xf_ready),
      .out_mag   (xf_mag)
   );

   foc_pwm_duty #(.DUTY_MAX(DUTY_MAX)) u_duty (
      .clock     (clock),
      .reset     (reset),
      .supply    (supply_ff),
      .in_valid  (xf_valid),
      .in_ready  (xf_ready),
      .in_mag    (xf_mag),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_duty  (duty)
   );

   assign rsp_duty_a = duty[0];
   assign rsp_duty_b = duty[1];
   assign rsp_duty_c = duty[2];

endmodule
`default_nettype wire

[hw/rtl/foc_pwm_sincos.sv]
// Two-stage sine/cosine unit: quadrant fold and table lookup, then interpolation.
// Depends on foc_pwm_pkg.
`default_nettype none
module foc_pwm_sincos
   import foc_pwm_pkg::*;
#(
   parameter int ANGLE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic signed [VOLT_W-1:0] in_volt_q,
   input  wire logic signed [VOLT_W-1:0] in_volt_d,
   input  wire logic [15:0]              in_angle,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output logic signed [VOLT_W-1:0]      out_volt_q,
   output logic signed [VOLT_W-1:0]      out_volt_d,
   output logic signed [SINE_W-1:0]      out_sin,
   output logic signed [SINE_W-1:0]      out_cos
);

   localparam int FB = ANGLE_BITS - 2 - SEG_BITS;   // interpolation fraction bits
   localparam int PW = ANGLE_BITS - 1;              // position 0..quarter inclusive
   localparam logic [PW-1:0] QUARTER = {1'b1, {(PW-1){1'b0}}};

   logic [ANGLE_BITS+15:0] ang_ext;
   logic [ANGLE_BITS-1:0]  ang;
   logic [1:0]             quad;
   logic [PW-1:0]          pos;
   logic [PW-1:0]          mpos;
   logic [PW-1:0]          arg [2];
   seg_idx_type            idx [2];
   sine_mag_type           lo_tab [2];
   sine_mag_type           hi_tab [2];
   sine_mag_type           step [2];
   logic                   neg_in [2];

   logic                   v1_ff, v2_ff;
   logic                   en1, en2;
   sine_mag_type           lo_ff [2];
   logic [DIFF_W-1:0]      diff_ff [2];
   logic [FB-1:0]          frac_ff [2];
   logic                   neg_ff [2];
   logic signed [VOLT_W-1:0] vq1_ff, vd1_ff, vq2_ff, vd2_ff;

   logic [DIFF_W+FB-1:0]   prod [2];
   logic [15:0]            mag [2];
   logic signed [SINE_W-1:0] val_in [2];
   logic signed [SINE_W-1:0] val_ff [2];

   // handshake: a stage loads when empty or when its successor moves
   assign en2      = !v2_ff || out_ready;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // fold the angle into the first quadrant; channel 0 is sine, 1 is cosine
   assign ang_ext = {{ANGLE_BITS{1'b0}}, in_angle};
   assign ang     = ang_ext[ANGLE_BITS-1:0];
   assign quad    = ang[ANGLE_BITS-1 -: 2];
   assign pos     = {1'b0, ang[ANGLE_BITS-3:0]};
   assign mpos    = QUARTER - pos;

   always_comb begin
      arg[0]    = quad[0] ? mpos : pos;
      arg[1]    = quad[0] ? pos : mpos;
      neg_in[0] = quad[1];
      neg_in[1] = quad[1] ^ quad[0];
      for (int i = 0; i < 2; i++) begin
         idx[i]    = arg[i][PW-1:FB];
         lo_tab[i] = quarter_sine(idx[i]);
         hi_tab[i] = (idx[i] == seg_idx_type'(SEGS)) ? lo_tab[i]
                                                      : quarter_sine(idx[i] + 6'd1);
         step[i]   = hi_tab[i] - lo_tab[i];
      end
   end

   // interpolate, truncating, then apply the quadrant sign
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         prod[i]   = DIFF_W'(diff_ff[i]) * (DIFF_W+FB)'(frac_ff[i]);
         mag[i]    = {1'b0, lo_ff[i]} + 16'(prod[i][DIFF_W+FB-1:FB]);
         val_in[i] = neg_ff[i] ? -$signed({1'b0, mag[i]}) : $signed({1'b0, mag[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
      if (en1) begin
         vq1_ff <= in_volt_q;
         vd1_ff <= in_volt_d;
         for (int i = 0; i < 2; i++) begin
            lo_ff[i]   <= lo_tab[i];
            diff_ff[i] <= step[i][DIFF_W-1:0];
            frac_ff[i] <= arg[i][FB-1:0];
            neg_ff[i]  <= neg_in[i];
         end
      end
      if (en2) begin
         vq2_ff    <= vq1_ff;
         vd2_ff    <= vd1_ff;
         val_ff[0] <= val_in[0];
         val_ff[1] <= val_in[1];
      end
   end

   assign out_valid  = v2_ff;
   assign out_volt_q = vq2_ff;
   assign out_volt_d = vd2_ff;
   assign out_sin    = val_ff[0];
   assign out_cos    = val_ff[1];

endmodule
`default_nettype wire

[hw/rtl/foc_pwm_xform.sv]
// Four-stage inverse Park / inverse Clarke datapath with clamp to 0..supply.
// Depends on foc_pwm_pkg.
`default_nettype none
module foc_pwm_xform
   import foc_pwm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [SUPPLY_W-1:0]        supply,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   input  wire logic signed [VOLT_W-1:0]   in_volt_q,
   input  wire logic signed [VOLT_W-1:0]   in_volt_d,
   input  wire logic signed [SINE_W-1:0]   in_sin,
   input  wire logic signed [SINE_W-1:0]   in_cos,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   output logic [MAG_W-1:0]                out_mag [3]
);

   localparam int PW = VOLT_W + SINE_W;   // 33-bit products
   localparam int AW = PW + 1;            // alpha / beta
   localparam int UW = 50;                // phase voltage, 2^-38 V

   logic [3:0] v_ff;
   logic [3:0] en;

   logic signed [PW-1:0] p_in [4];
   logic signed [PW-1:0] p_ff [4];
   logic signed [AW-1:0] alpha_in, beta_in, alpha_ff, beta_ff, alpha2_ff;
   logic signed [UW-1:0] pb_in, pb_ff;
   logic signed [UW-1:0] a14, u [3];
   logic [MAG_W-1:0]     full;
   logic [MAG_W-1:0]     mag_in [3];
   logic [MAG_W-1:0]     mag_ff [3];

   // stall chain, last stage first
   always_comb begin
      en[3] = !v_ff[3] || out_ready;
      for (int i = 2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
   end
   assign in_ready = en[0];

   // stage 1: the four rotation products
   assign p_in[0] = in_volt_d * in_cos;
   assign p_in[1] = in_volt_q * in_sin;
   assign p_in[2] = in_volt_d * in_sin;
   assign p_in[3] = in_volt_q * in_cos;

   // stage 2: alpha and beta
   assign alpha_in = {p_ff[0][PW-1], p_ff[0]} - {p_ff[1][PW-1], p_ff[1]};
   assign beta_in  = {p_ff[2][PW-1], p_ff[2]} + {p_ff[3][PW-1], p_ff[3]};

   // stage 3: beta * sqrt(3)/2
   assign pb_in = beta_ff * HALF_SQRT3_Q15;

   // stage 4: three phases, clamp to 0..supply
   always_comb begin
      full = {supply, 30'b0};
      a14  = {{(UW-AW-14){alpha2_ff[AW-1]}}, alpha2_ff, 14'b0};
      u[0] = {{(UW-AW-15){alpha2_ff[AW-1]}}, alpha2_ff, 15'b0};
      u[1] = pb_ff - a14;
      u[2] = -a14 - pb_ff;
      for (int i = 0; i < 3; i++) begin
         if (u[i] <= 0)
            mag_in[i] = '0;
         else if (u[i] > $signed({{(UW-MAG_W){1'b0}}, full}))
            mag_in[i] = full;
         else
            mag_in[i] = u[i][MAG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < 4; i++) if (en[i]) v_ff[i] <= v_ff[i-1];
      end
      if (en[0]) for (int i = 0; i < 4; i++) p_ff[i] <= p_in[i];
      if (en[1]) begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
      if (en[2]) begin
         alpha2_ff <= alpha_ff;
         pb_ff     <= pb_in;
      end
      if (en[3]) for (int i = 0; i < 3; i++) mag_ff[i] <= mag_in[i];
   end

   assign out_valid = v_ff[3];
   assign out_mag   = mag_ff;

endmodule
`default_nettype wire

[hw/rtl/foc_pwm_duty.sv]
// Duty scaling: voltage * DUTY_MAX / supply, one scale stage then one stage per
// quotient bit of a restoring divider, three phases side by side. Uses foc_pwm_pkg.
`default_nettype none
module foc_pwm_duty
   import foc_pwm_pkg::*;
#(
   parameter int DUTY_MAX = 255
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SUPPLY_W-1:0] supply,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic [MAG_W-1:0]    in_mag [3],
   output logic                     out_valid,
   input  wire logic                out_ready,
   output logic [7:0]               out_duty [3]
);

   localparam int QB = $clog2(DUTY_MAX + 1);
   localparam int TW = SUPPLY_W + QB;
   localparam int NS = QB + 1;
   localparam logic [QB-1:0] DMAX = QB'(DUTY_MAX);

   logic [NS-1:0]  v_ff;
   logic [NS-1:0]  en;
   logic [TW-1:0]  rem_ff [NS][3];
   logic [QB-1:0]  quo_ff [NS][3];
   logic [MAG_W+QB-1:0] scaled [3];
   logic [QB+7:0]  quo_ext [3];

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS-2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
   end
   assign in_ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= in_valid;
         for (int i = 1; i < NS; i++) if (en[i]) v_ff[i] <= v_ff[i-1];
      end
   end

   // scale stage: floor(mag * DUTY_MAX / 2^30), the 2^30 of the supply taken out here
   always_comb begin
      for (int p = 0; p < 3; p++) scaled[p] = in_mag[p] * (MAG_W+QB)'(DMAX);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int p = 0; p < 3; p++) begin
            rem_ff[0][p] <= scaled[p][MAG_W+QB-1:30];
            quo_ff[0][p] <= '0;
         end
      end
   end

   // restoring divide by supply, most significant quotient bit first
   for (genvar s = 1; s < NS; s++) begin : g_div
      localparam int K = QB - s;
      logic [TW-1:0] dvs;
      logic [TW-1:0] rem_in [3];
      logic [QB-1:0] quo_in [3];

      assign dvs = TW'(supply) << K;

      always_comb begin
         for (int p = 0; p < 3; p++) begin
            quo_in[p] = quo_ff[s-1][p];
            if (rem_ff[s-1][p] >= dvs) begin
               rem_in[p]    = rem_ff[s-1][p] - dvs;
               quo_in[p][K] = 1'b1;
            end else begin
               rem_in[p] = rem_ff[s-1][p];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[s]) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   // a zero supply gives zero duty; wider duties keep their low byte
   always_comb begin
      for (int p = 0; p < 3; p++) begin
         quo_ext[p]  = {8'b0, quo_ff[NS-1][p]};
         out_duty[p] = (supply == '0) ? 8'd0 : quo_ext[p][7:0];
      end
   end

   assign out_valid = v_ff[NS-1];

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for foc_phase_voltage_to_pwm: random and directed
// voltage commands, predicted duties compared in order. Depends on foc_pwm_pkg.
`default_nettype none
module testbench;
   import foc_pwm_pkg::*;

   typedef struct packed {
      logic signed [VOLT_W-1:0] vq;
      logic signed [VOLT_W-1:0] vd;
      logic [15:0]              angle;
   } cmd_type;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } duty_type;

   localparam int LIMIT = 400000;
   localparam int LATENCY = 15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [SUPPLY_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [VOLT_W-1:0] req_volt_q = '0;
   logic signed [VOLT_W-1:0] req_volt_d = '0;
   logic [15:0] req_elec_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_duty_a, rsp_duty_b, rsp_duty_c;

   cmd_type  cmd_queue[$];
   duty_type duty_expected[$];
   logic [SUPPLY_W-1:0] supply_model = SUPPLY_RESET;
   int errors = 0;
   int cycles = 0;
   int send_gap = 0;
   int recv_gap = 0;

   foc_phase_voltage_to_pwm #(.ANGLE_BITS(16), .DUTY_MAX(255)) u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // table sine, first quadrant position 0..16384
   function automatic longint quad_sine(input int pos);
      int idx, frac;
      longint lo, hi;
      idx = pos >> 9;
      frac = pos & 511;
      if (idx >= SEGS) return longint'(quarter_sine(seg_idx_type'(SEGS)));
      lo = longint'(quarter_sine(seg_idx_type'(idx)));
      hi = longint'(quarter_sine(seg_idx_type'(idx + 1)));
      return lo + (((hi - lo) * frac) >>> 9);
   endfunction

   function automatic longint angle_sine(input logic [15:0] ang);
      int pos;
      pos = int'(ang[13:0]);
      case (ang[15:14])
         2'd0: return quad_sine(pos);
         2'd1: return quad_sine(16384 - pos);
         2'd2: return -quad_sine(pos);
         default: return -quad_sine(16384 - pos);
      endcase
   endfunction

   function automatic logic [7:0] volts_to_duty(input longint u, input longint full);
      longint m;
      if (full == 0 || u <= 0) return 8'd0;
      m = (u > full) ? full : u;
      return 8'((m * 255) / full);
   endfunction

   function automatic duty_type phase_duties(input cmd_type cmd);
      longint s, c, alpha, beta, ua, ub, uc, full;
      duty_type r;
      s = angle_sine(cmd.angle);
      c = angle_sine(cmd.angle + 16'h4000);
      alpha = longint'(cmd.vd) * c - longint'(cmd.vq) * s;
      beta = longint'(cmd.vd) * s + longint'(cmd.vq) * c;
      ua = alpha * 32768;
      ub = -alpha * 16384 + beta * longint'(HALF_SQRT3_Q15);
      uc = -alpha * 16384 - beta * longint'(HALF_SQRT3_Q15);
      full = longint'(supply_model) << 30;
      r.a = volts_to_duty(ua, full);
      r.b = volts_to_duty(ub, full);
      r.c = volts_to_duty(uc, full);
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // driver: one word per handshake, random gap drawn after each
   always @(posedge clock) begin
      int gap;
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_valid && req_ready) begin
            duty_expected.push_back(phase_duties(
               '{vq: req_volt_q, vd: req_volt_d, angle: req_elec_angle}));
            void'(cmd_queue.pop_front());
            gap = $urandom_range(0, 6);
            if (gap == 0 && cmd_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_volt_q <= cmd_queue[0].vq;
               req_volt_d <= cmd_queue[0].vd;
               req_elec_angle <= cmd_queue[0].angle;
            end else begin
               req_valid <= 1'b0;
               send_gap <= (gap > 0) ? gap - 1 : 0;
            end
         end else if (!req_valid) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
            end else if (cmd_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_volt_q <= cmd_queue[0].vq;
               req_volt_d <= cmd_queue[0].vd;
               req_elec_angle <= cmd_queue[0].angle;
            end
         end
      end
   end

   // monitor: random stalls on the result side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (duty_expected.size() == 0) begin
               report_mismatch("unexpected word", 0, 0);
            end else begin
               duty_type w;
               w = duty_expected.pop_front();
               if (rsp_duty_a !== w.a) report_mismatch("duty_a", rsp_duty_a, w.a);
               if (rsp_duty_b !== w.b) report_mismatch("duty_b", rsp_duty_b, w.b);
               if (rsp_duty_c !== w.c) report_mismatch("duty_c", rsp_duty_c, w.c);
            end
         end
         if (recv_gap > 0) begin
            rsp_ready <= 1'b0;
            recv_gap <= recv_gap - 1;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready && $urandom_range(0, 3) != 0)
               recv_gap <= $urandom_range(0, 6);
         end
      end
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic cmd_type random_cmd();
      cmd_type cmd;
      cmd.vq = 16'($urandom);
      cmd.vd = 16'($urandom);
      cmd.angle = 16'($urandom);
      case ($urandom_range(0, 3))
         0: begin
            cmd.vq = 16'($signed(16'($urandom_range(0, 1600))) - 800);
            cmd.vd = 16'($signed(16'($urandom_range(0, 1600))) - 800);
         end
         1: cmd.vd = 16'($signed(16'($urandom_range(0, 256))) - 128);
         default: ;
      endcase
      return cmd;
   endfunction

   task automatic wait_drained();
      while (cmd_queue.size() != 0 || req_valid || duty_expected.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic write_supply(input logic [SUPPLY_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      supply_model <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [SUPPLY_W-1:0] settings[5];
      logic signed [15:0] edges[5];
      settings = '{15'd6144, 15'd1, 15'd32767, 15'd256, 15'd3000};
      edges = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: field extremes, quadrant boundaries, clamps, table end
      for (int i = 0; i < 5; i++)
         cmd_queue.push_back('{vq: edges[i], vd: edges[4 - i], angle: 16'(i * 16384)});
      cmd_queue.push_back('{vq: 16'sd1536, vd: 16'sd0, angle: 16'hFFFF});
      cmd_queue.push_back('{vq: -16'sd1536, vd: 16'sd0, angle: 16'h3FFF});
      cmd_queue.push_back('{vq: 16'sd3072, vd: 16'sd3072, angle: 16'h2AAA});
      cmd_queue.push_back('{vq: 16'sd0, vd: 16'sd512, angle: 16'h3E00});
      cmd_queue.push_back('{vq: 16'sd100, vd: -16'sd100, angle: 16'h8001});
      wait_drained();
      for (int p = 0; p < 5; p++) begin
         write_supply(settings[p]);
         for (int i = 0; i < 330; i++) cmd_queue.push_back(random_cmd());
         wait_drained();
      end
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
